// ===== design/gbp_pkg.sv =====
// gbp_pkg: shared types, codes and defaults for the gshare branch predictor
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package gbp_pkg;

   typedef logic [1:0] ctr_type;

   localparam int HISTORY_BITS_DEF = 12;
   localparam int TABLE_DEPTH_DEF  = 4096;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [0:0] CSR_IDX_MODE = 1'b0;

   localparam logic MODE_ALWAYS_TAKEN = 1'b0;
   localparam logic MODE_GSHARE       = 1'b1;
   localparam logic MODE_RESET        = MODE_GSHARE;

   localparam logic OP_PREDICT = 1'b0;
   localparam logic OP_UPDATE  = 1'b1;

   localparam ctr_type CTR_MIN   = 2'd0;
   localparam ctr_type CTR_RESET = 2'd2;
   localparam ctr_type CTR_MAX   = 2'd3;

   function automatic logic ctr_taken(input ctr_type ctr);
      return ctr[1];
   endfunction

   function automatic ctr_type ctr_step(input ctr_type ctr, input logic taken);
      ctr_type res;
      res = ctr;
      if (taken) begin
         if (ctr != CTR_MAX) res = ctr + 2'd1;
      end else begin
         if (ctr != CTR_MIN) res = ctr - 2'd1;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== design/gbp_table.sv =====
// gbp_table: counter table memory, one write and one registered read port
// runs a clearing pass after reset; depends on gbp_pkg
`timescale 1ns / 1ps
`default_nettype none

module gbp_table #(
   parameter int TABLE_DEPTH = gbp_pkg::TABLE_DEPTH_DEF,
   localparam int IDX_BITS = $clog2(TABLE_DEPTH)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  rd_en,
   input  wire logic [IDX_BITS-1:0]   rd_addr,
   output gbp_pkg::ctr_type           rd_data,
   input  wire logic                  wr_en,
   input  wire logic [IDX_BITS-1:0]   wr_addr,
   input  wire gbp_pkg::ctr_type      wr_data,
   output logic                       busy
);

   gbp_pkg::ctr_type ctr_mem [TABLE_DEPTH];
   gbp_pkg::ctr_type rd_data_ff;
   logic [IDX_BITS-1:0] clr_addr_ff, clr_addr_in;
   logic                clr_busy_ff, clr_busy_in;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == IDX_BITS'(TABLE_DEPTH - 1)) clr_busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         ctr_mem[clr_addr_ff] <= gbp_pkg::CTR_RESET;
      end else if (wr_en) begin
         ctr_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= ctr_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_busy_ff;

endmodule

`default_nettype wire

// ===== design/gbp_csr.sv =====
// gbp_csr: apb register block holding the prediction mode
// depends on gbp_pkg
`timescale 1ns / 1ps
`default_nettype none

module gbp_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [gbp_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  wire logic [gbp_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic      [gbp_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                     pready,
   output logic                                     mode
);

   logic mode_ff, mode_in;
   logic sel_mode;

   assign sel_mode = (paddr[gbp_pkg::CSR_ADDR_BITS-1] == gbp_pkg::CSR_IDX_MODE);
   assign pready   = 1'b1;

   always_comb begin
      mode_in = mode_ff;
      if (psel && penable && pwrite && pready && sel_mode) mode_in = pwdata[0];
   end

   always_ff @(posedge clock) begin
      if (reset) mode_ff <= gbp_pkg::MODE_RESET;
      else       mode_ff <= mode_in;
   end

   always_comb begin
      prdata = '0;
      if (sel_mode) prdata = {{(gbp_pkg::CSR_DATA_BITS-1){1'b0}}, mode_ff};
   end

   assign mode = mode_ff;

endmodule

`default_nettype wire

// ===== design/gshare_branch_predictor.sv =====
// gshare_branch_predictor: top level, request pipeline, history and statistics
// depends on gbp_pkg, gbp_table and gbp_csr
`timescale 1ns / 1ps
`default_nettype none

// One beat is taken per cycle unless the clearing pass runs or a waiting result stalls stage
// one: the table read is issued as a request is accepted, and in gshare mode the counter
// read-modify-write of an update closes in stage one on the single write port, with the new
// counter and the new history forwarded to the request that follows. A response register
// behind stage one lets the next request in while a result still waits. After reset a
// clearing pass sets all TABLE_DEPTH entries (4096 by default) to 2; no request is accepted
// until it ends, while register accesses go on. TABLE_DEPTH must be a power of two.
module gshare_branch_predictor #(
   parameter int HISTORY_BITS = gbp_pkg::HISTORY_BITS_DEF,
   parameter int TABLE_DEPTH  = gbp_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_op,
   input  wire logic [31:0]                         req_pc,
   input  wire logic                                req_resolved_taken,
   input  wire logic                                req_predicted_taken,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_predict_taken,
   output logic      [31:0]                         rsp_branch_count,
   output logic      [31:0]                         rsp_mispredict_count,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [gbp_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  wire logic [gbp_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic      [gbp_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                     pready
);

   localparam int IDX_BITS = $clog2(TABLE_DEPTH);

   logic mode;
   logic busy;

   logic [HISTORY_BITS-1:0] hist_ff, hist_in;
   logic [31:0]             branches_ff, branches_in;
   logic [31:0]             mispredicts_ff, mispredicts_in;

   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_op_ff;
   logic                    s1_resolved_ff;
   logic                    s1_predicted_ff;
   logic [IDX_BITS-1:0]     s1_idx_ff;
   logic                    s1_fwd_ff;
   gbp_pkg::ctr_type        s1_fwd_ctr_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_taken_ff;
   logic [31:0]             rsp_branches_ff;
   logic [31:0]             rsp_mispredicts_ff;

   logic                    accept;
   logic                    s1_adv;
   logic                    wr_en;
   logic [31:0]             pc_hash;
   logic [IDX_BITS-1:0]     req_idx;
   gbp_pkg::ctr_type        rd_data;
   gbp_pkg::ctr_type        ctr_cur;
   gbp_pkg::ctr_type        ctr_new;
   logic                    taken;

   gbp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .mode    (mode)
   );

   gbp_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (req_idx),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (s1_idx_ff),
      .wr_data (ctr_new),
      .busy    (busy)
   );

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !busy && (!s1_valid_ff || s1_adv);
   assign accept    = req_valid && req_ready;
   assign wr_en     = s1_adv && (s1_op_ff == gbp_pkg::OP_UPDATE) &&
                      (mode == gbp_pkg::MODE_GSHARE);

   assign ctr_cur = s1_fwd_ff ? s1_fwd_ctr_ff : rd_data;
   assign ctr_new = gbp_pkg::ctr_step(ctr_cur, s1_resolved_ff);

   always_comb begin
      hist_in = hist_ff;
      if (wr_en) hist_in = {hist_ff[HISTORY_BITS-2:0], s1_resolved_ff};
   end

   assign pc_hash = req_pc ^ {{(32-HISTORY_BITS){1'b0}}, hist_in};
   assign req_idx = pc_hash[IDX_BITS-1:0];

   always_comb begin
      taken = 1'b0;
      if (s1_op_ff == gbp_pkg::OP_PREDICT) begin
         taken = (mode == gbp_pkg::MODE_GSHARE) ? gbp_pkg::ctr_taken(ctr_cur) : 1'b1;
      end
   end

   always_comb begin
      branches_in    = branches_ff;
      mispredicts_in = mispredicts_ff;
      if (s1_adv) begin
         if (s1_op_ff == gbp_pkg::OP_PREDICT) begin
            branches_in = branches_ff + 32'd1;
         end else if (s1_resolved_ff != s1_predicted_ff) begin
            mispredicts_in = mispredicts_ff + 32'd1;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept)      s1_valid_in = 1'b1;
      else if (s1_adv) s1_valid_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv)         rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff        <= '0;
         branches_ff    <= '0;
         mispredicts_ff <= '0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         hist_ff        <= hist_in;
         branches_ff    <= branches_in;
         mispredicts_ff <= mispredicts_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff        <= req_op;
         s1_resolved_ff  <= req_resolved_taken;
         s1_predicted_ff <= req_predicted_taken;
         s1_idx_ff       <= req_idx;
         s1_fwd_ff       <= wr_en && (req_idx == s1_idx_ff);
         s1_fwd_ctr_ff   <= ctr_new;
      end
      if (s1_adv) begin
         rsp_taken_ff       <= taken;
         rsp_branches_ff    <= branches_in;
         rsp_mispredicts_ff <= mispredicts_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_predict_taken    = rsp_taken_ff;
   assign rsp_branch_count     = rsp_branches_ff;
   assign rsp_mispredict_count = rsp_mispredicts_ff;

   // no request enters during the clearing pass
   a_no_accept_busy : assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_ready)
      else $error("request accepted during table clear");

   // a stalled stage one holds its item
   a_s1_hold : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_idx_ff) && $stable(s1_op_ff)))
      else $error("stage one item lost while stalled");

   // each committed predict bumps the branch count by one
   a_branch_count : assert property (@(posedge clock) disable iff (reset)
      (s1_adv && (s1_op_ff == gbp_pkg::OP_PREDICT)) |=>
         (branches_ff == ($past(branches_ff) + 32'd1)))
      else $error("branch count did not advance");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// tb_top: self-checking bench for gshare_branch_predictor, random and directed beats
// keeps its own pattern table, history and statistics to predict every response
// depends on gbp_pkg and the gshare_branch_predictor rtl
`timescale 1ns / 1ps

module tb_top;

   localparam int HIST_BITS  = gbp_pkg::HISTORY_BITS_DEF;
   localparam int DEPTH      = gbp_pkg::TABLE_DEPTH_DEF;
   localparam int IDX_BITS   = $clog2(DEPTH);
   localparam int CYCLE_CAP  = 60000;
   localparam int POOL       = 8;
   localparam int HOLD_LEN   = 60;
   localparam int IDLE_PCT   = 29;

   localparam logic [gbp_pkg::CSR_ADDR_BITS-1:0] MODE_ADDR   = {gbp_pkg::CSR_IDX_MODE, 2'b00};
   localparam logic [gbp_pkg::CSR_ADDR_BITS-1:0] UNUSED_ADDR = 3'd4;
   localparam gbp_pkg::ctr_type CTR_TAKEN_MIN = 2'd2;

   typedef struct packed {
      logic        op;
      logic [31:0] pc;
      logic        resolved;
      logic        predicted;
   } branch_op_type;

   typedef struct packed {
      logic        taken;
      logic [31:0] branches;
      logic [31:0] mispredicts;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_op = gbp_pkg::OP_PREDICT;
   logic [31:0] req_pc = '0;
   logic        req_resolved_taken = 1'b0;
   logic        req_predicted_taken = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_predict_taken;
   logic [31:0] rsp_branch_count;
   logic [31:0] rsp_mispredict_count;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [gbp_pkg::CSR_ADDR_BITS-1:0] paddr = '0;
   logic [gbp_pkg::CSR_DATA_BITS-1:0] pwdata = '0;
   logic [gbp_pkg::CSR_DATA_BITS-1:0] prdata;
   logic        pready;

   // shadow state of the predictor
   gbp_pkg::ctr_type      pht [DEPTH];
   logic [HIST_BITS-1:0]  ghist = '0;
   logic [31:0]           n_branches = '0;
   logic [31:0]           n_mispred = '0;
   logic                  mode_now = gbp_pkg::MODE_RESET;

   branch_op_type branch_ops [$];
   outcome_type   outcomes_due [$];
   branch_op_type drv_op;
   outcome_type   due;

   logic        req_beat = 1'b0;
   logic        steady = 1'b0;
   logic        hold_go = 1'b0;
   logic        hold_done = 1'b0;
   int          hold_left = 0;
   int          ops_queued = 0;
   int          ops_taken = 0;
   int          n_updates = 0;
   int          n_checked = 0;
   int          fail_cnt = 0;
   int          cycle_cnt = 0;

   logic [31:0] pool_pc [POOL];
   logic        pool_dir [POOL];

   gshare_branch_predictor dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_op               (req_op),
      .req_pc               (req_pc),
      .req_resolved_taken   (req_resolved_taken),
      .req_predicted_taken  (req_predicted_taken),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_predict_taken    (rsp_predict_taken),
      .rsp_branch_count     (rsp_branch_count),
      .rsp_mispredict_count (rsp_mispredict_count),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
         fail_cnt++;
      end
   endtask

   // advance the shadow predictor by one beat and queue its response
   task automatic branch_step(input branch_op_type b);
      outcome_type o;
      logic [31:0] mix;
      logic [IDX_BITS-1:0] idx;
      mix = b.pc ^ 32'(ghist);
      idx = mix[IDX_BITS-1:0];
      o.taken = 1'b0;
      if (b.op == gbp_pkg::OP_PREDICT) begin
         n_branches = n_branches + 32'd1;
         o.taken = (mode_now == gbp_pkg::MODE_GSHARE) ? (pht[idx] >= CTR_TAKEN_MIN) : 1'b1;
      end else begin
         n_updates++;
         if (b.resolved != b.predicted) n_mispred = n_mispred + 32'd1;
         if (mode_now == gbp_pkg::MODE_GSHARE) begin
            if (b.resolved && pht[idx] != gbp_pkg::CTR_MAX) pht[idx] = pht[idx] + 2'd1;
            else if (!b.resolved && pht[idx] != gbp_pkg::CTR_MIN) pht[idx] = pht[idx] - 2'd1;
            ghist = {ghist[HIST_BITS-2:0], b.resolved};
         end
      end
      o.branches = n_branches;
      o.mispredicts = n_mispred;
      outcomes_due.push_back(o);
   endtask

   // request driver
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_beat)) begin
         if (branch_ops.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
            drv_op = branch_ops.pop_front();
            req_valid <= 1'b1;
            req_op <= drv_op.op;
            req_pc <= drv_op.pc;
            req_resolved_taken <= drv_op.resolved;
            req_predicted_taken <= drv_op.predicted;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response sink with one long hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_go && !hold_done) begin
         hold_left <= HOLD_LEN;
         hold_done <= 1'b1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // monitor: requests feed the shadow predictor, responses are compared in order
   always @(posedge clock) begin
      req_beat <= req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            branch_step(branch_op_type'{req_op, req_pc, req_resolved_taken,
                                        req_predicted_taken});
            ops_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (outcomes_due.size() == 0) begin
               $display("%0t: response beat with nothing outstanding, got %b %h %h", $time,
                        rsp_predict_taken, rsp_branch_count, rsp_mispredict_count);
               fail_cnt++;
            end else begin
               due = outcomes_due.pop_front();
               check_field("predict_taken", 32'(due.taken), 32'(rsp_predict_taken));
               check_field("branch_count", due.branches, rsp_branch_count);
               check_field("mispredict_count", due.mispredicts, rsp_mispredict_count);
               n_checked++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_CAP) begin
         $display("%0t: timeout with %0d responses outstanding", $time, outcomes_due.size());
         $display("** gshare_branch_predictor: FAILED **");
         $finish;
      end
   end

   task automatic push_op(input logic op, input logic [31:0] pc, input logic res,
                          input logic pred);
      branch_ops.push_back(branch_op_type'{op, pc, res, pred});
      ops_queued++;
   endtask

   task automatic drain();
      while (ops_taken != ops_queued || outcomes_due.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_write(input logic [gbp_pkg::CSR_ADDR_BITS-1:0] addr,
                            input logic [31:0] data);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == MODE_ADDR) mode_now = data[0];
   endtask

   task automatic csr_read_check(input logic [gbp_pkg::CSR_ADDR_BITS-1:0] addr,
                                 input logic [31:0] want);
      logic [31:0] got;
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= addr;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      got = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      check_field("mode readback", want, got);
   endtask

   // mostly predict/update pairs on a small set of biased branches, plus noise
   task automatic queue_random_ops(input int count);
      int made;
      int k;
      logic res;
      logic pred;
      made = 0;
      while (made < count) begin
         if ($urandom_range(99) < 70) begin
            k = $urandom_range(POOL - 1);
            res = ($urandom_range(99) < 85) ? pool_dir[k] : ~pool_dir[k];
            pred = ($urandom_range(99) < 70) ? pool_dir[k] : 1'($urandom_range(1));
            push_op(gbp_pkg::OP_PREDICT, pool_pc[k], 1'($urandom_range(1)),
                    1'($urandom_range(1)));
            push_op(gbp_pkg::OP_UPDATE, pool_pc[k], res, pred);
            made += 2;
         end else begin
            push_op($urandom_range(1) ? gbp_pkg::OP_UPDATE : gbp_pkg::OP_PREDICT, $urandom,
                    1'($urandom_range(1)), 1'($urandom_range(1)));
            made++;
         end
      end
   endtask

   initial begin
      int i;
      for (i = 0; i < DEPTH; i++) pht[i] = gbp_pkg::CTR_RESET;
      for (i = 0; i < POOL; i++) begin
         pool_pc[i] = $urandom;
         pool_dir[i] = 1'($urandom_range(1));
      end
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      csr_read_check(MODE_ADDR, 32'(gbp_pkg::MODE_RESET));

      // gshare: saturate low, saturate high, history aliasing, pc extremes
      push_op(gbp_pkg::OP_PREDICT, 32'h0000_0000, 1'b0, 1'b0);
      push_op(gbp_pkg::OP_UPDATE,  32'h0000_0000, 1'b0, 1'b1);
      push_op(gbp_pkg::OP_UPDATE,  32'hFFFF_F000, 1'b0, 1'b0);
      push_op(gbp_pkg::OP_UPDATE,  32'h0000_0000, 1'b0, 1'b0);
      push_op(gbp_pkg::OP_PREDICT, 32'hFFFF_F000, 1'b1, 1'b1);
      push_op(gbp_pkg::OP_UPDATE,  32'h0000_0005, 1'b1, 1'b0);
      push_op(gbp_pkg::OP_UPDATE,  32'h0000_0004, 1'b1, 1'b1);
      push_op(gbp_pkg::OP_PREDICT, 32'h0000_0006, 1'b0, 1'b0);
      push_op(gbp_pkg::OP_PREDICT, 32'hFFFF_FFFF, 1'b0, 1'b0);
      push_op(gbp_pkg::OP_UPDATE,  32'hFFFF_FFFF, 1'b0, 1'b1);
      push_op(gbp_pkg::OP_PREDICT, 32'h8000_0FFA, 1'b0, 1'b0);
      push_op(gbp_pkg::OP_UPDATE,  32'hAAAA_AAAA, 1'b1, 1'b0);
      push_op(gbp_pkg::OP_UPDATE,  32'h5555_5555, 1'b0, 1'b1);
      push_op(gbp_pkg::OP_PREDICT, 32'h0000_0000, 1'b0, 1'b0);
      drain();

      // always-taken: table and history frozen, mispredicts still counted
      csr_write(MODE_ADDR, {$urandom} & ~32'd1 | 32'(gbp_pkg::MODE_ALWAYS_TAKEN));
      csr_read_check(MODE_ADDR, 32'(gbp_pkg::MODE_ALWAYS_TAKEN));
      push_op(gbp_pkg::OP_PREDICT, 32'h0000_0000, 1'b0, 1'b0);
      push_op(gbp_pkg::OP_PREDICT, 32'hFFFF_FFFF, 1'b1, 1'b1);
      push_op(gbp_pkg::OP_UPDATE,  32'h0000_0000, 1'b1, 1'b0);
      push_op(gbp_pkg::OP_UPDATE,  32'hFFFF_FFFF, 1'b0, 1'b0);
      push_op(gbp_pkg::OP_UPDATE,  32'h1234_5678, 1'b1, 1'b1);
      push_op(gbp_pkg::OP_PREDICT, 32'h0000_0FFA, 1'b0, 1'b0);
      drain();

      // write to an address past the register list is ignored
      csr_write(UNUSED_ADDR, 32'hFFFF_FFFF);
      csr_read_check(MODE_ADDR, 32'(gbp_pkg::MODE_ALWAYS_TAKEN));

      csr_write(MODE_ADDR, {$urandom} | 32'(gbp_pkg::MODE_GSHARE));
      csr_read_check(MODE_ADDR, 32'(gbp_pkg::MODE_GSHARE));
      queue_random_ops(250);
      drain();

      csr_write(MODE_ADDR, 32'hFFFF_FFFE);
      queue_random_ops(100);
      drain();

      // no idling on either side, with one long response hold-off up front
      csr_write(MODE_ADDR, 32'(gbp_pkg::MODE_GSHARE));
      queue_random_ops(200);
      steady = 1'b1;
      hold_go = 1'b1;
      drain();
      steady = 1'b0;

      $display("run covered %0d predict and %0d update beats across both modes,",
               n_branches, n_updates);
      $display("with %0d responses compared field by field", n_checked);
      if (fail_cnt == 0 && outcomes_due.size() == 0) begin
         $display("** gshare_branch_predictor: PASSED **");
      end else begin
         $display("** gshare_branch_predictor: FAILED **");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/gbp_pkg.sv
design/gbp_table.sv
design/gbp_csr.sv
design/gshare_branch_predictor.sv
test/tb_top.sv
